// ===== sv/kts_pkg.sv =====
// Package: constants and types shared by the topological sort block.
package kts_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int NodeW = 6;
  localparam int EdgeW = 8;
  localparam int CntW = 9;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CYCLE   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic {
    FN_EDGE   = 1'b0,
    FN_FINISH = 1'b1
  } func_t;
endpackage

// ===== sv/kts_if.sv =====
// Interfaces: valid/ready channels for edge and finish items and for order items.
interface kts_in_if;
  import kts_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [NodeW-1:0] dependent_node;
  logic [NodeW-1:0] prerequisite_node;
  modport source(output valid, func, dependent_node, prerequisite_node, input ready);
  modport sink(input valid, func, dependent_node, prerequisite_node, output ready);
endinterface

interface kts_out_if;
  import kts_pkg::*;
  logic             valid;
  logic             ready;
  logic [NodeW-1:0] node;
  logic [1:0]       status;
  logic             last;
  modport source(output valid, node, status, last, input ready);
  modport sink(input valid, node, status, last, output ready);
endinterface

// ===== sv/kts_edge_mem.sv =====
// Edge store: one write port, one registered read port.
module kts_edge_mem
  import kts_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [EdgeW-1:0] waddr,
  input  logic [NodeW-1:0] wsrc,
  input  logic [NodeW-1:0] wdst,
  input  logic [EdgeW-1:0] raddr,
  output logic [NodeW-1:0] rsrc,
  output logic [NodeW-1:0] rdst
);
  logic [2*NodeW-1:0] mem [MaxEdges];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wsrc, wdst};
    end
    {rsrc, rdst} <= mem[raddr];
  end
endmodule

// ===== sv/kts_node_mem.sv =====
// Node store: indegree counts indexed by node, and one array that serves as ready queue and order list, in flops.
module kts_node_mem
  import kts_pkg::*;
(
  input  logic             clk,
  input  logic             deg_we,
  input  logic [NodeW-1:0] deg_waddr,
  input  logic [CntW-1:0]  deg_wdata,
  input  logic [NodeW-1:0] deg_raddr,
  output logic [CntW-1:0]  deg_rdata,
  input  logic             q_we,
  input  logic [NodeW-1:0] q_waddr,
  input  logic [NodeW-1:0] q_wdata,
  input  logic [NodeW-1:0] q_raddr,
  output logic [NodeW-1:0] q_rdata
);
  logic [CntW-1:0]  deg [MaxNodes];
  logic [NodeW-1:0] q   [MaxNodes];

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg[deg_waddr] <= deg_wdata;
    end
    deg_rdata <= deg[deg_raddr];
    if (q_we) begin
      q[q_waddr] <= q_wdata;
    end
    q_rdata <= q[q_raddr];
  end
endmodule

// ===== sv/kahn_topological_sort.sv =====
// Top level: Kahn topological sort over stored edges.
// Edge items are taken one per cycle while in load and only stored (an out-of-range
// edge or one past the store's capacity is flagged as dropped); indegrees are rebuilt
// at finish. A finish item runs a check pass over the E stored edges, clears the
// indegree store and, unless an edge was dropped, counts indegrees and seeds the queue.
// Each ordered node is then popped and all E stored edges are scanned for it (one
// edge-store read per cycle). The order streams out while the receiver keeps up, or a
// dropped or cycle status is sent, and a wipe of the indegree store follows. Input is
// not taken again until the last result item of the run has been accepted.
module kahn_topological_sort
  import kts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  kts_in_if.sink     in_ch,
  kts_out_if.source  out_ch
);
  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_CLEAR = 9'b000000100,
    S_COUNT = 9'b000001000,
    S_SEED  = 9'b000010000,
    S_POP   = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_WIPE  = 9'b100000000
  } state_t;

  state_t state;
  logic [6:0] num_nodes;
  logic [6:0] n_lim;
  logic [CntW-1:0] edge_total;
  logic dropped;
  logic [CntW-1:0] e_ptr;
  logic [6:0] i_ptr;
  logic [6:0] head, tail, count;
  logic [NodeW-1:0] cur;
  logic sub;  // pipeline phase within a node or edge step
  logic [1:0] pv;  // count/scan pipeline valid bits
  logic [NodeW-1:0] pend_node;
  logic [CntW-1:0] pend_val;
  logic pend_v;

  always_comb begin
    if (num_nodes == 7'd0) n_lim = 7'd1;
    else if (num_nodes > 7'(MaxNodes)) n_lim = 7'(MaxNodes);
    else n_lim = num_nodes;
  end

  logic             e_we;
  logic [EdgeW-1:0] e_raddr;
  logic [NodeW-1:0] e_src, e_dst;
  logic             d_we;
  logic [NodeW-1:0] d_waddr, d_raddr;
  logic [CntW-1:0]  d_wdata, d_rdata;
  logic             q_we;
  logic [NodeW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

  kts_edge_mem u_edge (
    .clk(clk), .we(e_we), .waddr(edge_total[EdgeW-1:0]),
    .wsrc(in_ch.prerequisite_node), .wdst(in_ch.dependent_node),
    .raddr(e_raddr), .rsrc(e_src), .rdst(e_dst)
  );
  kts_node_mem u_node (
    .clk(clk), .deg_we(d_we), .deg_waddr(d_waddr), .deg_wdata(d_wdata),
    .deg_raddr(d_raddr), .deg_rdata(d_rdata), .q_we(q_we), .q_waddr(q_waddr),
    .q_wdata(q_wdata), .q_raddr(q_raddr), .q_rdata(q_rdata)
  );

  logic in_fire, edge_ok;
  assign in_ch.ready = (state == S_LOAD);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign edge_ok = ({1'b0, in_ch.dependent_node} < n_lim) &&
                   ({1'b0, in_ch.prerequisite_node} < n_lim) &&
                   (edge_total < CntW'(MaxEdges));
  assign e_we = in_fire && (in_ch.func == FN_EDGE) && edge_ok;

  // Degree pipeline stage registers for count and scan: stage1 edge read, stage2 deg read.
  logic s1_hit;
  logic [NodeW-1:0] s1_t;
  logic [CntW-1:0] deg_fwd;
  logic [CntW-1:0] deg_dec;
  assign deg_fwd = (pend_v && pend_node == s1_t) ? pend_val : d_rdata;
  assign deg_dec = deg_fwd - CntW'(1);

  // Memory address/write muxing.
  always_comb begin
    e_raddr = e_ptr[EdgeW-1:0];
    d_raddr = in_ch.dependent_node;
    d_we = 1'b0;
    d_waddr = pend_node;
    d_wdata = pend_val;
    q_we = 1'b0;
    q_waddr = tail[NodeW-1:0];
    q_wdata = i_ptr[NodeW-1:0];
    q_raddr = head[NodeW-1:0];
    unique case (state)
      S_LOAD: ;
      S_CHECK: d_raddr = i_ptr[NodeW-1:0];
      S_CLEAR: begin
        d_we = 1'b1;
        d_waddr = i_ptr[NodeW-1:0];
        d_wdata = '0;
      end
      S_COUNT: begin
        d_raddr = e_dst;
        d_we = pv[1];
        d_waddr = s1_t;
        d_wdata = deg_fwd + CntW'(1);
      end
      S_SEED: begin
        d_raddr = i_ptr[NodeW-1:0];
        q_we = sub && (d_rdata == '0) && (i_ptr < n_lim);
      end
      S_POP: q_raddr = head[NodeW-1:0];
      S_SCAN: begin
        d_raddr = e_dst;
        d_we = pv[1] && s1_hit && (deg_fwd != '0);
        d_waddr = s1_t;
        d_wdata = deg_dec;
        q_we = s1_hit && pv[1] && (deg_fwd != '0) && (deg_dec == '0);
        q_wdata = s1_t;
      end
      S_EMIT: q_raddr = i_ptr[NodeW-1:0];
      S_WIPE: begin
        d_we = 1'b1;
        d_waddr = i_ptr[NodeW-1:0];
        d_wdata = '0;
      end
      default: ;
    endcase
  end

  // Output register.
  logic ov;
  logic [NodeW-1:0] onode;
  logic [1:0] ostat;
  logic olast;
  logic emit_rd;  // q_rdata holds the next order entry
  assign out_ch.valid = ov;
  assign out_ch.node = onode;
  assign out_ch.status = ostat;
  assign out_ch.last = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      num_nodes <= 7'(MaxNodes);
      edge_total <= '0;
      dropped <= 1'b0;
      pend_v <= 1'b0;
      ov <= 1'b0;
      pv <= '0;
      i_ptr <= '0;
      e_ptr <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
      sub <= 1'b0;
      emit_rd <= 1'b0;
    end else begin
      if (cfg_we) num_nodes <= cfg_wdata;
      if (ov && out_ch.ready) ov <= 1'b0;
      pend_v <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (in_ch.func == FN_EDGE) begin
              if (edge_ok) edge_total <= edge_total + CntW'(1);
              else dropped <= 1'b1;
            end else begin
              state <= S_CHECK;
              e_ptr <= '0;
              i_ptr <= '0;
              sub <= 1'b0;
            end
          end
        end
        S_CHECK: begin
          // stage: read edge at e_ptr, check it in the next cycle
          if (sub && ({1'b0, e_src} >= n_lim || {1'b0, e_dst} >= n_lim)) dropped <= 1'b1;
          if (e_ptr < edge_total) begin
            e_ptr <= e_ptr + CntW'(1);
            sub <= 1'b1;
          end else if (sub) begin
            sub <= 1'b0;
          end else begin
            state <= S_CLEAR;
            i_ptr <= '0;
          end
        end
        S_CLEAR: begin
          i_ptr <= i_ptr + 7'd1;
          if (i_ptr == 7'(MaxNodes - 1)) begin
            i_ptr <= '0;
            e_ptr <= '0;
            pv <= '0;
            if (dropped) begin
              onode <= '0; ostat <= ST_DROPPED; olast <= 1'b1; ov <= 1'b1;
              state <= S_WIPE;
            end else state <= S_COUNT;
          end
        end
        S_COUNT: begin
          // pv[0]: edge read issued; pv[1]: deg read issued
          pv <= {pv[0], e_ptr < edge_total};
          if (e_ptr < edge_total) e_ptr <= e_ptr + CntW'(1);
          s1_t <= e_dst;
          if (pv[1]) begin
            pend_v <= 1'b1;
            pend_node <= s1_t;
            pend_val <= deg_fwd + CntW'(1);
          end
          if (pv[0]) s1_hit <= 1'b1;
          if (!pv[0] && !pv[1] && e_ptr >= edge_total && e_ptr != '0 ||
              (edge_total == '0)) begin
            state <= S_SEED; i_ptr <= '0; sub <= 1'b0; tail <= '0; head <= '0;
            count <= '0;
          end
        end
        S_SEED: begin
          if (!sub) sub <= 1'b1;
          else begin
            sub <= 1'b0;
            if ((d_rdata == '0) && (i_ptr < n_lim)) tail <= tail + 7'd1;
            i_ptr <= i_ptr + 7'd1;
            if (i_ptr == 7'(MaxNodes - 1)) begin
              state <= S_POP; sub <= 1'b0;
            end
          end
        end
        S_POP: begin
          if (!sub) begin
            if (head < tail) sub <= 1'b1;
            else if (count != n_lim) begin
              onode <= '0; ostat <= ST_CYCLE; olast <= 1'b1; ov <= 1'b1;
              state <= S_WIPE; i_ptr <= '0;
            end else begin
              state <= S_EMIT; i_ptr <= '0; emit_rd <= 1'b0;
            end
          end else begin
            sub <= 1'b0;
            cur <= q_rdata;
            head <= head + 7'd1;
            count <= count + 7'd1;
            e_ptr <= '0;
            pv <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pv <= {pv[0], e_ptr < edge_total};
          if (e_ptr < edge_total) e_ptr <= e_ptr + CntW'(1);
          s1_t <= e_dst;
          s1_hit <= (e_src == cur);
          if (pv[1] && s1_hit && deg_fwd != '0) begin
            pend_v <= 1'b1;
            pend_node <= s1_t;
            pend_val <= deg_dec;
            if (deg_dec == '0) tail <= tail + 7'd1;
          end
          if (!pv[0] && !pv[1] && e_ptr >= edge_total) begin
            state <= S_POP; sub <= 1'b0;
          end
        end
        S_EMIT: begin
          if (!ov || out_ch.ready) begin
            if (emit_rd) begin
              onode <= q_rdata; ostat <= ST_OK;
              olast <= (i_ptr + 7'd1 == count); ov <= 1'b1;
              emit_rd <= 1'b0;
              if (i_ptr + 7'd1 == count) begin
                state <= S_WIPE; i_ptr <= '0;
              end else begin
                i_ptr <= i_ptr + 7'd1;
              end
            end else begin
              emit_rd <= 1'b1;
            end
          end
        end
        S_WIPE: begin
          // wipe the indegree store, then hold here until the last result item has left
          if (i_ptr != 7'(MaxNodes)) i_ptr <= i_ptr + 7'd1;
          else if (!ov) begin
            edge_total <= '0; dropped <= 1'b0; state <= S_LOAD; i_ptr <= '0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !ov || state == S_LOAD)
    else $error("input taken outside load");
  assert property (@(posedge clk) disable iff (rst)
    (ov && out_ch.ready && out_ch.last) |=> state == S_WIPE || state == S_LOAD)
    else $error("last item before wipe");
  assert property (@(posedge clk) disable iff (rst)
    tail <= 7'(MaxNodes))
    else $error("queue overflow");
endmodule
